FILE: design/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants of the sensor packet deframer.
// ----------------------------------------------------------------------------
package ipd_pkg;

  // Byte that opens every packet.
  localparam logic [7:0] HEADER_BYTE = 8'hFF;

  // Bytes after the header that carry the nine 16-bit words.
  localparam int PAYLOAD_BYTES = 18;
  localparam int NUM_WORDS     = PAYLOAD_BYTES / 2;

  // Reset value of the declination offset: the mean of the two local
  // declinations, in units of 180/32768 degree.
  localparam logic [15:0] DECL_RESET = 16'd2541;

  // One beat of the byte channel and one field of the result.
  typedef logic [7:0]         byte_t;
  typedef logic signed [15:0] word_t;

  // Event from the framer to the result stage: a packet has just closed.
  typedef struct packed {
    logic                             done;
    logic                             ok;
    logic [PAYLOAD_BYTES-1:0][7:0]    bytes;
  } ipd_pkt_t;

endpackage

FILE: design/ipd_if.sv
// ----------------------------------------------------------------------------
// ipd_byte_if / ipd_result_if
// Valid/ready channels of the deframer: serial bytes in, decoded packets out.
// ----------------------------------------------------------------------------
interface ipd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ipd_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_raw;
  logic signed [15:0] pitch_raw;
  logic signed [15:0] heading_raw;
  logic        [15:0] heading_corrected;
  logic signed [15:0] roll_rate_raw;
  logic signed [15:0] pitch_rate_raw;
  logic signed [15:0] yaw_rate_raw;
  logic signed [15:0] accel_x_raw;
  logic signed [15:0] accel_y_raw;
  logic signed [15:0] accel_z_raw;
  logic               checksum_ok;

  modport source (
    output valid, input ready,
    output roll_raw, output pitch_raw, output heading_raw, output heading_corrected,
    output roll_rate_raw, output pitch_rate_raw, output yaw_rate_raw,
    output accel_x_raw, output accel_y_raw, output accel_z_raw, output checksum_ok
  );
  modport sink (
    input valid, output ready,
    input roll_raw, input pitch_raw, input heading_raw, input heading_corrected,
    input roll_rate_raw, input pitch_rate_raw, input yaw_rate_raw,
    input accel_x_raw, input accel_y_raw, input accel_z_raw, input checksum_ok
  );
endinterface

FILE: design/ipd_framer.sv
// ----------------------------------------------------------------------------
// ipd_framer
// Header hunt, byte counter, running mod-256 sum and payload shift store.
// ----------------------------------------------------------------------------
module ipd_framer
  import ipd_pkg::*;
#(
  parameter int PACKET_BYTES = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  ipd_byte_if.sink         in_ch,
  input  logic             res_room,
  output ipd_pkt_t         pkt
);

  localparam int POS_W = $clog2(PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_IDLE    = '0;
  localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(PAYLOAD_BYTES);

  logic [POS_W-1:0]                 pos_r,   pos_nxt;
  logic [7:0]                       sum_r,   sum_nxt;
  logic [PAYLOAD_BYTES-1:0][7:0]    store_r, store_nxt;
  logic                             at_last;
  logic                             accept;

  // Only the checksum beat needs room in the result register.
  assign at_last      = (pos_r == POS_LAST);
  assign in_ch.ready  = !at_last || res_room;
  assign accept       = in_ch.valid && in_ch.ready;

  // Next state of the counter, the sum and the store.
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    store_nxt = store_r;
    if (accept) begin
      if (pos_r == POS_IDLE) begin
        if (in_ch.rx_byte == HEADER_BYTE) begin
          pos_nxt = POS_FIRST;
          sum_nxt = '0;
        end
      end else if (!at_last) begin
        // Newest byte enters at the top; after the payload bytes the oldest
        // sits at index 0.
        if (pos_r <= POS_PAYLOAD) begin
          store_nxt = {in_ch.rx_byte, store_r[PAYLOAD_BYTES-1:1]};
        end
        sum_nxt = sum_r + in_ch.rx_byte;
        pos_nxt = pos_r + POS_FIRST;
      end else begin
        pos_nxt = POS_IDLE;
      end
    end
  end

  // Packet-closed event towards the result stage.
  assign pkt.done  = accept && at_last;
  assign pkt.ok    = (sum_r == in_ch.rx_byte);
  assign pkt.bytes = store_r;

  // Control state is reset; the payload store is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule

FILE: design/ipd_result.sv
// ----------------------------------------------------------------------------
// ipd_result
// Declination register and the output register that holds one decoded packet.
// ----------------------------------------------------------------------------
module ipd_result
  import ipd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  ipd_pkt_t         pkt,
  output logic             res_room,
  ipd_result_if.source     out_ch
);

  logic                           valid_r;
  logic [15:0]                    decl_r;
  logic [NUM_WORDS-1:0][15:0]     word_r, word_nxt;
  logic [15:0]                    hdg_cor_r, hdg_cor_nxt;
  logic                           ok_r;

  // The register is free when empty or being emptied in this cycle.
  assign res_room = !valid_r || out_ch.ready;

  // Big-endian words; a failed packet reports all fields as zero.
  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      word_nxt[k] = pkt.ok ? {pkt.bytes[2*k], pkt.bytes[2*k+1]} : 16'd0;
    end
    hdg_cor_nxt = pkt.ok ? (word_nxt[2] + decl_r) : 16'd0;
  end

  // Valid flag and declination register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      decl_r  <= DECL_RESET;
    end else begin
      if (pkt.done) begin
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        decl_r <= cfg_wr_data;
      end
    end
  end

  // Payload of the result register.
  always_ff @(posedge clk) begin
    if (pkt.done) begin
      word_r    <= word_nxt;
      hdg_cor_r <= hdg_cor_nxt;
      ok_r      <= pkt.ok;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.roll_raw          = signed'(word_r[0]);
  assign out_ch.pitch_raw         = signed'(word_r[1]);
  assign out_ch.heading_raw       = signed'(word_r[2]);
  assign out_ch.heading_corrected = hdg_cor_r;
  assign out_ch.roll_rate_raw     = signed'(word_r[3]);
  assign out_ch.pitch_rate_raw    = signed'(word_r[4]);
  assign out_ch.yaw_rate_raw      = signed'(word_r[5]);
  assign out_ch.accel_x_raw       = signed'(word_r[6]);
  assign out_ch.accel_y_raw       = signed'(word_r[7]);
  assign out_ch.accel_z_raw       = signed'(word_r[8]);
  assign out_ch.checksum_ok       = ok_r;

endmodule

FILE: design/imu_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// imu_packet_deframer_top
// Deframes 0xFF-headed sensor packets and checks their mod-256 checksum.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received serial byte per beat. While idle, bytes other
//   than 0xFF are dropped. A 0xFF header starts a packet of PACKET_BYTES
//   bytes; the last byte is the checksum of those between header and end.
//   out_ch carries one beat per packet: nine signed words, the heading with
//   the declination offset added, and checksum_ok. A failed packet gives
//   checksum_ok low and every other field zero.
//   cfg_wr_en/cfg_wr_data write the declination offset (reset 2541).
// Throughput and latency:
//   One byte per cycle unless a waiting result holds off the checksum byte.
//   The result appears in the cycle after the checksum byte is taken.
// Reset (synchronous, rst_n low) returns the block to header hunting and
//   empties the output register.
// Stall: while a result waits, bytes are still taken; only the next checksum
//   byte is held off until the waiting result has been taken.
// ----------------------------------------------------------------------------
module imu_packet_deframer_top
  import ipd_pkg::*;
#(
  parameter int PACKET_BYTES = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  ipd_byte_if.sink         in_ch,
  ipd_result_if.source     out_ch,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);

  ipd_pkt_t pkt;
  logic     res_room;

  // Byte counting, sum and payload store.
  ipd_framer #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .res_room (res_room),
    .pkt      (pkt)
  );

  // Output register and declination offset.
  ipd_result u_result (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pkt         (pkt),
    .res_room    (res_room),
    .out_ch      (out_ch)
  );

endmodule

FILE: design/ipd_checker.sv
// ----------------------------------------------------------------------------
// ipd_checker
// Port-level checks of the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ipd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               checksum_ok,
  input logic signed [15:0] roll_raw,
  input logic signed [15:0] heading_raw,
  input logic        [15:0] heading_corrected,
  input logic signed [15:0] accel_z_raw
);

  // A waiting result stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // The output register is empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // A fresh result needs an input beat in the cycle before.
  a_fresh_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
    else $error("result beat without a preceding byte beat");

  // A failed packet reports zero in roll, heading, corrected heading and accel_z.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !checksum_ok |-> roll_raw == 16'sd0 && heading_raw == 16'sd0 &&
                                  heading_corrected == 16'd0 && accel_z_raw == 16'sd0)
    else $error("failed packet carries non-zero data");

endmodule

bind imu_packet_deframer_top ipd_checker u_ipd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .checksum_ok       (out_ch.checksum_ok),
  .roll_raw          (out_ch.roll_raw),
  .heading_raw       (out_ch.heading_raw),
  .heading_corrected (out_ch.heading_corrected),
  .accel_z_raw       (out_ch.accel_z_raw)
);
